FILE: design/assert_macros.svh
// assertion helpers used by the checker module aabb_chk
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is held
`define AABB_ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also runs through reset
`define AABB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/aabb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aabb_pkg
// shared constants and types for the bounding box builder
// ----------------------------------------------------------------------------
package aabb_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int COEFF_WIDTH_DEF = 16;

  localparam int OP_W      = 2;
  localparam int CFG_IDX_W = 3;

  // operation codes
  localparam logic [OP_W-1:0] OP_START = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
  localparam logic [OP_W-1:0] OP_TEST  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Z = 3'd5;

  // stage enables handed to the transform rows
  typedef struct packed {
    logic mul_en;
    logic sum_en;
  } pipe_ctl_t;

endpackage
`default_nettype wire

FILE: design/aabb_row.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aabb_row
// one output axis of the affine transform: registered products, then
// sum, fraction drop, translation and saturation into a registered result
// ----------------------------------------------------------------------------
module aabb_row #(
  parameter int COORD_WIDTH = aabb_pkg::COORD_WIDTH_DEF,
  parameter int COEFF_WIDTH = aabb_pkg::COEFF_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire aabb_pkg::pipe_ctl_t           ctl,
  input  wire logic [3*COEFF_WIDTH-1:0]      coef_row,
  input  wire logic signed [COORD_WIDTH-1:0] shift,
  input  wire logic signed [COORD_WIDTH-1:0] pt_x,
  input  wire logic signed [COORD_WIDTH-1:0] pt_y,
  input  wire logic signed [COORD_WIDTH-1:0] pt_z,
  output logic signed [COORD_WIDTH-1:0]      t_r
);

  localparam int PROD_W = COORD_WIDTH + COEFF_WIDTH;
  localparam int SUM_W  = PROD_W + 2;
  localparam int FRAC   = COEFF_WIDTH / 2;
  localparam int SCL_W  = SUM_W - FRAC;
  localparam int TOT_W  = SCL_W + 1;

  logic signed [COEFF_WIDTH-1:0] k    [3];
  logic signed [COORD_WIDTH-1:0] p    [3];
  logic signed [PROD_W-1:0]      prod_r   [3];
  logic signed [PROD_W-1:0]      prod_nxt [3];

  logic signed [SUM_W-1:0] sum;
  logic signed [SCL_W-1:0] scaled;
  logic signed [TOT_W-1:0] total;
  logic                    fits;
  logic signed [COORD_WIDTH-1:0] t_nxt;

  always_comb begin
    p[0] = pt_x;
    p[1] = pt_y;
    p[2] = pt_z;
    for (int c = 0; c < 3; c++) begin
      k[c]        = coef_row[c*COEFF_WIDTH +: COEFF_WIDTH];
      prod_nxt[c] = PROD_W'(k[c]) * PROD_W'(p[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= prod_nxt;
    end
  end

  // exact sum, floor drop of the fraction, then translate and clamp
  always_comb begin
    sum    = SUM_W'(prod_r[0]) + SUM_W'(prod_r[1]) + SUM_W'(prod_r[2]);
    scaled = sum[SUM_W-1:FRAC];
    total  = TOT_W'(scaled) + TOT_W'(shift);
    fits   = (&total[TOT_W-1:COORD_WIDTH-1]) | ~(|total[TOT_W-1:COORD_WIDTH-1]);
    if (fits) begin
      t_nxt = total[COORD_WIDTH-1:0];
    end else if (total[TOT_W-1]) begin
      t_nxt = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    end else begin
      t_nxt = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.sum_en) begin
      t_r <= t_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: design/aabb_build_and_overlap.sv
`default_nettype none
// a beat passes in order through four register stages (input, products,
//   transformed point, box/result), each moving on when the stage ahead frees;
// throughput: one beat per cycle while neither in_stall nor out_stall holds the flow
// reset: synchronous, clears the box to zero, empties every stage and
//   loads the identity transform with zero translation
// ----------------------------------------------------------------------------
// aabb_build_and_overlap
// builds an axis-aligned box from transformed vertices and tests it against
// a given box for overlap on all three axes
// ----------------------------------------------------------------------------
module aabb_build_and_overlap #(
  parameter int COORD_WIDTH = aabb_pkg::COORD_WIDTH_DEF,
  parameter int COEFF_WIDTH = aabb_pkg::COEFF_WIDTH_DEF,
  localparam int CFG_W = (3 * COEFF_WIDTH > COORD_WIDTH) ? 3 * COEFF_WIDTH : COORD_WIDTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // configuration writes
  input  wire logic                            cfg_wr_en,
  input  wire logic [aabb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]                cfg_data,
  // input beats
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [aabb_pkg::OP_W-1:0]       in_op,
  input  wire logic signed [COORD_WIDTH-1:0]   in_corner_a_x,
  input  wire logic signed [COORD_WIDTH-1:0]   in_corner_a_y,
  input  wire logic signed [COORD_WIDTH-1:0]   in_corner_a_z,
  input  wire logic signed [COORD_WIDTH-1:0]   in_corner_b_x,
  input  wire logic signed [COORD_WIDTH-1:0]   in_corner_b_y,
  input  wire logic signed [COORD_WIDTH-1:0]   in_corner_b_z,
  // result beats
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic signed [COORD_WIDTH-1:0]        out_box_min_x,
  output logic signed [COORD_WIDTH-1:0]        out_box_min_y,
  output logic signed [COORD_WIDTH-1:0]        out_box_min_z,
  output logic signed [COORD_WIDTH-1:0]        out_box_max_x,
  output logic signed [COORD_WIDTH-1:0]        out_box_max_y,
  output logic signed [COORD_WIDTH-1:0]        out_box_max_z,
  output logic                                 out_hit
);

  localparam int ROW_W = 3 * COEFF_WIDTH;
  localparam int FRAC  = COEFF_WIDTH / 2;

  // --------------------------------------------------------------------------
  // configuration: three coefficient rows and three translations
  // --------------------------------------------------------------------------
  logic [ROW_W-1:0]              coef_r  [3];
  logic signed [COORD_WIDTH-1:0] shift_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 3; r++) begin
        // 1.0 on the diagonal
        coef_r[r]  <= ROW_W'(1) << (r * COEFF_WIDTH + FRAC);
        shift_r[r] <= '0;
      end
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        aabb_pkg::REG_ROW_X:   coef_r[0]  <= cfg_data[ROW_W-1:0];
        aabb_pkg::REG_ROW_Y:   coef_r[1]  <= cfg_data[ROW_W-1:0];
        aabb_pkg::REG_ROW_Z:   coef_r[2]  <= cfg_data[ROW_W-1:0];
        aabb_pkg::REG_SHIFT_X: shift_r[0] <= cfg_data[COORD_WIDTH-1:0];
        aabb_pkg::REG_SHIFT_Y: shift_r[1] <= cfg_data[COORD_WIDTH-1:0];
        aabb_pkg::REG_SHIFT_Z: shift_r[2] <= cfg_data[COORD_WIDTH-1:0];
        default: ; // unknown index, write dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // pipeline flow: each stage moves on when the one ahead is empty or moving
  // --------------------------------------------------------------------------
  logic v0_r, v1_r, v2_r, out_valid_r;
  logic v0_nxt, v1_nxt, v2_nxt, out_valid_nxt;
  logic in_acc, en1, en2, en3;
  aabb_pkg::pipe_ctl_t row_ctl;

  always_comb begin
    en3    = v2_r && (!out_valid_r || !out_stall);
    en2    = v1_r && (!v2_r || en3);
    en1    = v0_r && (!v1_r || en2);
    in_acc = in_valid && (!v0_r || en1);

    v0_nxt        = in_acc ? 1'b1 : (en1 ? 1'b0 : v0_r);
    v1_nxt        = en1 ? 1'b1 : (en2 ? 1'b0 : v1_r);
    v2_nxt        = en2 ? 1'b1 : (en3 ? 1'b0 : v2_r);
    out_valid_nxt = en3 ? 1'b1 : (out_stall ? out_valid_r : 1'b0);

    row_ctl.mul_en = en1;
    row_ctl.sum_en = en2;
  end

  assign in_stall  = v0_r && !en1;
  assign out_valid = out_valid_r;

  // --------------------------------------------------------------------------
  // stage payloads: op and both corners travel alongside the transform
  // --------------------------------------------------------------------------
  logic [aabb_pkg::OP_W-1:0]     op0_r, op1_r, op2_r;
  logic signed [COORD_WIDTH-1:0] a0_r [3];
  logic signed [COORD_WIDTH-1:0] b0_r [3];
  logic signed [COORD_WIDTH-1:0] a1_r [3];
  logic signed [COORD_WIDTH-1:0] b1_r [3];
  logic signed [COORD_WIDTH-1:0] a2_r [3];
  logic signed [COORD_WIDTH-1:0] b2_r [3];

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op0_r   <= in_op;
      a0_r[0] <= in_corner_a_x;
      a0_r[1] <= in_corner_a_y;
      a0_r[2] <= in_corner_a_z;
      b0_r[0] <= in_corner_b_x;
      b0_r[1] <= in_corner_b_y;
      b0_r[2] <= in_corner_b_z;
    end
    if (en1) begin
      op1_r <= op0_r;
      a1_r  <= a0_r;
      b1_r  <= b0_r;
    end
    if (en2) begin
      op2_r <= op1_r;
      a2_r  <= a1_r;
      b2_r  <= b1_r;
    end
  end

  // --------------------------------------------------------------------------
  // transform rows: products in stage 1, clamped point in stage 2
  // --------------------------------------------------------------------------
  logic signed [COORD_WIDTH-1:0] t_r [3];

  for (genvar g = 0; g < 3; g++) begin : g_row
    aabb_row #(
      .COORD_WIDTH (COORD_WIDTH),
      .COEFF_WIDTH (COEFF_WIDTH)
    ) u_row (
      .clk      (clk),
      .ctl      (row_ctl),
      .coef_row (coef_r[g]),
      .shift    (shift_r[g]),
      .pt_x     (a0_r[0]),
      .pt_y     (a0_r[1]),
      .pt_z     (a0_r[2]),
      .t_r      (t_r[g])
    );
  end

  // --------------------------------------------------------------------------
  // box update and overlap test; the box registers are the result payload,
  // so a stalled result beat holds because the box only moves on en3
  // --------------------------------------------------------------------------
  logic signed [COORD_WIDTH-1:0] box_lo_r   [3];
  logic signed [COORD_WIDTH-1:0] box_hi_r   [3];
  logic signed [COORD_WIDTH-1:0] box_lo_nxt [3];
  logic signed [COORD_WIDTH-1:0] box_hi_nxt [3];
  logic [2:0]                    axis_ov;
  logic                          hit_r, hit_nxt;

  always_comb begin
    box_lo_nxt = box_lo_r;
    box_hi_nxt = box_hi_r;
    hit_nxt    = 1'b0;
    // inclusive per-axis rule; an inverted given box is taken as it is
    for (int i = 0; i < 3; i++) begin
      axis_ov[i] = (box_lo_r[i] <= a2_r[i] && a2_r[i] <= box_hi_r[i]) ||
                   (a2_r[i] <= box_lo_r[i] && box_lo_r[i] <= b2_r[i]);
    end
    unique case (op2_r)
      aabb_pkg::OP_START: begin
        for (int i = 0; i < 3; i++) begin
          box_lo_nxt[i] = t_r[i];
          box_hi_nxt[i] = t_r[i];
        end
      end
      aabb_pkg::OP_ADD: begin
        for (int i = 0; i < 3; i++) begin
          if (t_r[i] < box_lo_r[i]) box_lo_nxt[i] = t_r[i];
          if (t_r[i] > box_hi_r[i]) box_hi_nxt[i] = t_r[i];
        end
      end
      aabb_pkg::OP_TEST: begin
        hit_nxt = &axis_ov;
      end
      default: ; // unused selector: box kept, no hit
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        box_lo_r[i] <= '0;
        box_hi_r[i] <= '0;
      end
    end else begin
      v0_r        <= v0_nxt;
      v1_r        <= v1_nxt;
      v2_r        <= v2_nxt;
      out_valid_r <= out_valid_nxt;
      if (en3) begin
        box_lo_r <= box_lo_nxt;
        box_hi_r <= box_hi_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      hit_r <= hit_nxt;
    end
  end

  assign out_box_min_x = box_lo_r[0];
  assign out_box_min_y = box_lo_r[1];
  assign out_box_min_z = box_lo_r[2];
  assign out_box_max_x = box_hi_r[0];
  assign out_box_max_y = box_hi_r[1];
  assign out_box_max_z = box_hi_r[2];
  assign out_hit       = hit_r;

endmodule
`default_nettype wire

FILE: design/aabb_chk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aabb_chk
// port-level checks on the bounding box builder, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module aabb_chk #(
  parameter int COORD_WIDTH = aabb_pkg::COORD_WIDTH_DEF
) (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_stall,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic signed [COORD_WIDTH-1:0] out_box_min_x,
  input wire logic signed [COORD_WIDTH-1:0] out_box_min_y,
  input wire logic signed [COORD_WIDTH-1:0] out_box_min_z,
  input wire logic signed [COORD_WIDTH-1:0] out_box_max_x,
  input wire logic signed [COORD_WIDTH-1:0] out_box_max_y,
  input wire logic signed [COORD_WIDTH-1:0] out_box_max_z,
  input wire logic                          out_hit
);

  logic [6*COORD_WIDTH:0] out_beat;
  logic                   hold_req;
  logic                   box_ordered;

  // whole result payload as one vector
  assign out_beat    = {out_box_min_x, out_box_min_y, out_box_min_z,
                        out_box_max_x, out_box_max_y, out_box_max_z, out_hit};
  assign hold_req    = out_valid && out_stall;
  assign box_ordered = (out_box_min_x <= out_box_max_x) &&
                       (out_box_min_y <= out_box_max_y) &&
                       (out_box_min_z <= out_box_max_z);

  // a stalled result beat keeps its payload
  `AABB_ASSERT_CLK(a_out_hold, hold_req |=> out_valid && $stable(out_beat), "stalled beat changed")

  // the box is never inverted: start makes a point, add only widens
  `AABB_ASSERT_CLK(a_box_order, out_valid |-> box_ordered, "box minimum above maximum")

  // out of reset the pipeline is empty and ready
  `AABB_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid && !in_stall, "pipeline not empty")

endmodule

bind aabb_build_and_overlap aabb_chk #(.COORD_WIDTH(COORD_WIDTH)) u_chk (.*);
`default_nettype wire
